>>> rtl/core/rtcsr_pkg.sv
// Shared types, constants and helper functions for the CMOS RTC snapshot reader.
package rtcsr_pkg;

    localparam int SNAP_DEPTH = 7;
    localparam int NUM_FIELDS = 6;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [6:0] IDX_STATUS_A = 7'h0A;
    localparam logic [6:0] IDX_STATUS_B = 7'h0B;

    localparam int UIP_BIT    = 7;
    localparam int PM_BIT     = 7;
    localparam int MODE_BIN   = 2;
    localparam int MODE_24H   = 1;

    localparam logic REG_CENTURY   = 1'b0;
    localparam logic REG_BASE_YEAR = 1'b1;

    localparam logic [13:0] BASE_YEAR_RST = 14'd2024;
    localparam logic [7:0]  BASE_CENT_RST = 8'd20;

    typedef struct packed {
        logic [6:0]  century_index;
        logic [13:0] base_year;
        logic [7:0]  base_cent;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  sec;
        logic [7:0]  min;
        logic [7:0]  hour;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [15:0] year;
    } time_t;

    typedef logic [SNAP_DEPTH-1:0][7:0] snap_t;

    function automatic logic [6:0] field_index(input logic [2:0] pos);
        logic [6:0] idx;
        begin
            unique case (pos)
                3'd0:    idx = 7'h00;
                3'd1:    idx = 7'h02;
                3'd2:    idx = 7'h04;
                3'd3:    idx = 7'h07;
                3'd4:    idx = 7'h08;
                3'd5:    idx = 7'h09;
                default: idx = 7'h00;
            endcase
            return idx;
        end
    endfunction

    // high nibble times ten is (n << 3) + (n << 1)
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        logic [7:0] hi;
        begin
            hi = {4'b0, v[7:4]};
            return {4'b0, v[3:0]} + (hi << 3) + (hi << 1);
        end
    endfunction

endpackage

>>> rtl/core/rtcsr_req_if.sv
// Request channel: opcode and returned CMOS byte.
interface rtcsr_req_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] read_byte;

    modport source (output valid, output opcode, output read_byte, input ready);
    modport sink (input valid, input opcode, input read_byte, output ready);
endinterface

>>> rtl/core/rtcsr_res_if.sv
// Result channel: read request index or converted time.
interface rtcsr_res_if;
    logic        valid;
    logic        ready;
    logic        done_res;
    logic [6:0]  reg_index;
    logic [7:0]  sec_out;
    logic [7:0]  min_out;
    logic [7:0]  hour_out;
    logic [7:0]  day_out;
    logic [7:0]  month_out;
    logic [15:0] full_year;

    modport source (output valid, output done_res, output reg_index, output sec_out,
                    output min_out, output hour_out, output day_out, output month_out,
                    output full_year, input ready);
    modport sink (input valid, input done_res, input reg_index, input sec_out,
                  input min_out, input hour_out, input day_out, input month_out,
                  input full_year, output ready);
endinterface

>>> rtl/core/rtcsr_cfg.sv
// APB configuration registers and the derived base century.
module rtcsr_cfg
    import rtcsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [6:0]  century_reg;
    logic [13:0] base_year_reg;
    logic [7:0]  base_cent_reg;
    logic [26:0] cent_prod;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // base_year / 100 as (x * 5243) >> 19, exact for 14-bit x
    assign cent_prod = 27'(base_year_reg) * 27'd5243;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            century_reg   <= '0;
            base_year_reg <= BASE_YEAR_RST;
            base_cent_reg <= BASE_CENT_RST;
        end
        else
        begin
            base_cent_reg <= cent_prod[26:19];
            if (wr_en)
            begin
                unique case (paddr[2])
                    REG_CENTURY:   century_reg   <= pwdata[6:0];
                    REG_BASE_YEAR: base_year_reg <= pwdata[13:0];
                    default:       century_reg   <= century_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_CENTURY:   prdata = {25'b0, century_reg};
            REG_BASE_YEAR: prdata = {18'b0, base_year_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.century_index = century_reg;
    assign cfg.base_year     = base_year_reg;
    assign cfg.base_cent     = base_cent_reg;

endmodule

>>> rtl/core/rtcsr_conv.sv
// BCD, 12/24-hour and full-year conversion of a stable snapshot.
module rtcsr_conv
    import rtcsr_pkg::*;
(
    input  snap_t      snap,
    input  logic [7:0] mode_byte,
    input  cfg_t       cfg,
    output time_t      tm
);

    logic        is_bin;
    logic        has_cent;
    logic [7:0]  hour_b;
    logic [7:0]  hour_v;
    logic [7:0]  hour_q;
    logic [14:0] hour_prod;
    logic [7:0]  hour_f;
    logic [7:0]  yr_b;
    logic [7:0]  cent_b;
    logic [15:0] yr_cent;
    logic [15:0] yr_base;
    logic [15:0] yr_f;
    logic [6:0]  hr_lo;

    assign is_bin   = mode_byte[MODE_BIN];
    assign has_cent = (cfg.century_index != '0);
    assign hr_lo    = 7'({4'b0, snap[2][6:4]} * 7'd10) + {3'b0, snap[2][3:0]};

    always_comb
    begin
        tm.sec   = is_bin ? snap[0] : bcd_to_bin(snap[0]);
        tm.min   = is_bin ? snap[1] : bcd_to_bin(snap[1]);
        tm.day   = is_bin ? snap[3] : bcd_to_bin(snap[3]);
        tm.month = is_bin ? snap[4] : bcd_to_bin(snap[4]);
        yr_b     = is_bin ? snap[5] : bcd_to_bin(snap[5]);
        cent_b   = is_bin ? snap[6] : bcd_to_bin(snap[6]);
        hour_b   = is_bin ? snap[2] : {snap[2][PM_BIT], hr_lo};

        // (v + 12) mod 24, quotient as (v * 43) >> 10 for v <= 139
        hour_v    = {1'b0, hour_b[6:0]} + 8'd12;
        hour_prod = 15'(hour_v) * 15'd43;
        hour_q    = {5'b0, hour_prod[12:10]};
        hour_f    = hour_v - 8'(hour_q * 8'd24);
        tm.hour   = (!mode_byte[MODE_24H] && hour_b[PM_BIT]) ? hour_f : hour_b;

        yr_cent = 16'(yr_b) + 16'(cent_b) * 16'd100;
        yr_base = 16'(yr_b) + 16'(cfg.base_cent) * 16'd100;
        yr_f    = (yr_base < 16'(cfg.base_year)) ? yr_base + 16'd100 : yr_base;
        tm.year = has_cent ? yr_cent : yr_f;
    end

endmodule

>>> rtl/core/cmos_rtc_snapshot_reader.sv
// Top level: CMOS RTC snapshot reader with input register, sequencer and result register.
//
//  channel  | dir | handshake        | payload
//  req_ch   | in  | valid/ready      | opcode, read_byte
//  res_ch   | out | valid/ready      | done_res, reg_index, sec..month_out, full_year
//  apb      | in  | psel/penable     | paddr[2:0], pwdata/prdata 32 bits
//
// One item per cycle while res_ch is not stalled; each item is held in the input
// register and its result is registered in the result register. The sequencer
// step and the time conversion are a single pass between those two registers.
// A stalled result holds the result register; the input register fills and
// then req_ch.ready drops. rst_n clears control state and resets the config registers.
module cmos_rtc_snapshot_reader
    import rtcsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rtcsr_req_if.sink   req_ch,
    rtcsr_res_if.source res_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_POLL = 2'd1;
    localparam logic [1:0] PH_READ = 2'd2;
    localparam logic [1:0] PH_REGB = 2'd3;

    cfg_t        cfg;
    time_t       tm;

    logic        in_valid_reg;
    logic        in_op_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic        have_prev_reg, have_prev_next;
    snap_t       now_reg;
    snap_t       prev_reg;
    snap_t       now_merged;

    logic [2:0]  pos;
    logic [2:0]  count;
    logic        same;
    logic        wr_now;
    logic        wr_prev;
    logic        emit;
    logic        emit_done;
    logic [6:0]  emit_idx;

    logic        out_valid_reg;
    logic        done_reg;
    logic [6:0]  idx_reg;
    time_t       tm_reg;

    rtcsr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rtcsr_conv u_conv (
        .snap      (now_reg),
        .mode_byte (in_byte_reg),
        .cfg       (cfg),
        .tm        (tm)
    );

    assign advance      = in_valid_reg & (~out_valid_reg | res_ch.ready);
    assign req_ch.ready = ~in_valid_reg | advance;

    assign pos   = (pos_reg > 3'd6) ? 3'd6 : pos_reg;
    assign count = (cfg.century_index != '0) ? 3'd7 : 3'd6;

    always_comb
    begin
        for (int i = 0; i < SNAP_DEPTH; i++)
        begin
            now_merged[i] = (3'(i) == pos) ? in_byte_reg : now_reg[i];
        end
        same = 1'b1;
        for (int i = 0; i < SNAP_DEPTH; i++)
        begin
            if ((3'(i) < count) && (now_merged[i] != prev_reg[i]))
            begin
                same = 1'b0;
            end
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        have_prev_next = have_prev_reg;
        wr_now         = 1'b0;
        wr_prev        = 1'b0;
        emit           = 1'b0;
        emit_done      = 1'b0;
        emit_idx       = IDX_STATUS_A;
        if (in_op_reg == OP_START)
        begin
            have_prev_next = 1'b0;
            pos_next       = '0;
            phase_next     = PH_POLL;
            emit           = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    emit = 1'b0;
                end
                PH_POLL:
                begin
                    emit = 1'b1;
                    if (!in_byte_reg[UIP_BIT])
                    begin
                        phase_next = PH_READ;
                        pos_next   = '0;
                        emit_idx   = field_index(3'd0);
                    end
                end
                PH_READ:
                begin
                    emit   = 1'b1;
                    wr_now = 1'b1;
                    if ((pos + 3'd1) < count)
                    begin
                        pos_next = pos + 3'd1;
                        emit_idx = ((pos + 3'd1) < 3'(NUM_FIELDS)) ?
                                   field_index(pos + 3'd1) : cfg.century_index;
                    end
                    else
                    begin
                        pos_next = '0;
                        if (have_prev_reg && same)
                        begin
                            phase_next = PH_REGB;
                            emit_idx   = IDX_STATUS_B;
                        end
                        else
                        begin
                            wr_prev        = 1'b1;
                            have_prev_next = 1'b1;
                            phase_next     = PH_POLL;
                        end
                    end
                end
                PH_REGB:
                begin
                    emit       = 1'b1;
                    emit_done  = 1'b1;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ch.ready)
            begin
                in_valid_reg <= req_ch.valid;
            end
            if (advance)
            begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                have_prev_reg <= have_prev_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ch.ready && req_ch.valid)
        begin
            in_op_reg   <= req_ch.opcode;
            in_byte_reg <= req_ch.read_byte;
        end
        if (advance && wr_now)
        begin
            now_reg <= now_merged;
        end
        if (advance && wr_prev)
        begin
            prev_reg <= now_merged;
        end
        if (advance && emit)
        begin
            done_reg <= emit_done;
            idx_reg  <= emit_done ? '0 : emit_idx;
            tm_reg   <= emit_done ? tm : '0;
        end
    end

    assign res_ch.valid     = out_valid_reg;
    assign res_ch.done_res  = done_reg;
    assign res_ch.reg_index = idx_reg;
    assign res_ch.sec_out   = tm_reg.sec;
    assign res_ch.min_out   = tm_reg.min;
    assign res_ch.hour_out  = tm_reg.hour;
    assign res_ch.day_out   = tm_reg.day;
    assign res_ch.month_out = tm_reg.month;
    assign res_ch.full_year = tm_reg.year;

endmodule

>>> sim/tb_cmos_rtc_snapshot_reader.sv
// Testbench for the CMOS RTC snapshot reader: directed table, then emulated clock reads.
module tb_cmos_rtc_snapshot_reader;
    timeunit 1ns;
    timeprecision 1ps;
    import rtcsr_pkg::*;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_POLL, SEQ_READ, SEQ_REGB} seq_phase_e;
    typedef enum bit [1:0] {ROW_MODEL, ROW_NONE, ROW_REQ, ROW_TIME} row_kind_e;

    typedef struct packed {
        logic        done_res;
        logic [6:0]  reg_index;
        logic [7:0]  sec_out;
        logic [7:0]  min_out;
        logic [7:0]  hour_out;
        logic [7:0]  day_out;
        logic [7:0]  month_out;
        logic [15:0] full_year;
    } rtc_res_t;

    typedef struct packed {
        bit        op;
        bit [7:0]  data;
        row_kind_e kind;
        bit [6:0]  idx;
        bit [7:0]  sec;
        bit [7:0]  mnt;
        bit [7:0]  hr;
        bit [7:0]  dy;
        bit [7:0]  mon;
        bit [15:0] yr;
    } dir_row_t;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 64;
    localparam int RAND_ITEMS    = 230;
    localparam int NUM_SETTINGS  = 6;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rtcsr_req_if req_ch();
    rtcsr_res_if res_ch();

    cmos_rtc_snapshot_reader u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_ch  (req_ch),
        .res_ch  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // predictor state
    logic [6:0]  cfg_century;
    logic [13:0] cfg_base_year;
    seq_phase_e  seq_phase;
    logic [2:0]  seq_pos;
    logic [7:0]  snap_cur [7];
    logic [7:0]  snap_last [7];
    logic        snap_valid;
    logic [7:0]  status_b;
    logic [6:0]  field_idx [6] = '{7'h00, 7'h02, 7'h04, 7'h07, 7'h08, 7'h09};

    // emulated CMOS contents
    logic [7:0]  cmos_mem [128];

    rtc_res_t    awaited_results [$];
    int          mismatches;
    int          cycles;
    int          results_seen;
    int          reads_done;
    int          uip_polls;
    int          retries;
    int          aborts;
    int          ignored;
    bit          src_gaps;
    bit          sink_gaps;
    bit          hold_req;

    dir_row_t dir_rows [24] = '{
        '{OP_DATA,  8'hA5, ROW_NONE,  7'h00, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_START, 8'h3C, ROW_REQ,   7'h0A, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h80, ROW_REQ,   7'h0A, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_START, 8'hFF, ROW_REQ,   7'h0A, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h7F, ROW_REQ,   7'h00, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h59, ROW_MODEL, 7'h00, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h59, ROW_MODEL, 7'h00, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h92, ROW_MODEL, 7'h00, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h31, ROW_MODEL, 7'h00, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h12, ROW_MODEL, 7'h00, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h00, ROW_REQ,   7'h0A, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h00, ROW_REQ,   7'h00, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h59, ROW_MODEL, 7'h00, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h59, ROW_MODEL, 7'h00, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h92, ROW_MODEL, 7'h00, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h31, ROW_MODEL, 7'h00, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h12, ROW_MODEL, 7'h00, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h00, ROW_REQ,   7'h0B, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h00, ROW_TIME,  7'h00, 8'd59, 8'd59, 8'd0, 8'd31, 8'd12, 16'd2100},
        '{OP_DATA,  8'h5A, ROW_NONE,  7'h00, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_START, 8'h00, ROW_REQ,   7'h0A, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h00, ROW_REQ,   7'h00, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_DATA,  8'h11, ROW_MODEL, 7'h00, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0},
        '{OP_START, 8'h00, ROW_REQ,   7'h0A, 8'd0,  8'd0,  8'd0, 8'd0,  8'd0,  16'd0}
    };

    function automatic logic [7:0] bcd_value(input logic [7:0] v);
        int t;
        t = v[3:0] + v[7:4] * 10;
        return t[7:0];
    endfunction

    function automatic logic [7:0] to_bcd(input int n);
        return {4'(n / 10), 4'(n % 10)};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch(what, {16'd0, got}, {16'd0, want});
    endtask

    task automatic rtc_predict(input logic op, input logic [7:0] b,
                               output logic has, output rtc_res_t r);
        int cnt;
        int p;
        int i;
        int hv;
        int year;
        logic same;
        logic [7:0] s, m, h, d, mo, yr, ce;
        r = '0;
        has = 1'b1;
        if (op == OP_START)
        begin
            snap_valid = 1'b0;
            seq_pos = 3'd0;
            seq_phase = SEQ_POLL;
            r.reg_index = IDX_STATUS_A;
        end
        else
        begin
            case (seq_phase)
                SEQ_POLL:
                begin
                    if (b[UIP_BIT])
                        r.reg_index = IDX_STATUS_A;
                    else
                    begin
                        seq_phase = SEQ_READ;
                        seq_pos = 3'd0;
                        r.reg_index = field_idx[0];
                    end
                end
                SEQ_READ:
                begin
                    p = (seq_pos > 3'd6) ? 6 : seq_pos;
                    cnt = (cfg_century != 7'd0) ? 7 : 6;
                    snap_cur[p] = b;
                    if (p + 1 < cnt)
                    begin
                        seq_pos = 3'(p + 1);
                        r.reg_index = (p + 1 < 6) ? field_idx[p + 1] : cfg_century;
                    end
                    else
                    begin
                        same = 1'b1;
                        for (i = 0; i < cnt; i++)
                            if (snap_cur[i] != snap_last[i])
                                same = 1'b0;
                        seq_pos = 3'd0;
                        if (snap_valid && same)
                        begin
                            seq_phase = SEQ_REGB;
                            r.reg_index = IDX_STATUS_B;
                        end
                        else
                        begin
                            if (snap_valid)
                                retries++;
                            snap_last = snap_cur;
                            snap_valid = 1'b1;
                            seq_phase = SEQ_POLL;
                            r.reg_index = IDX_STATUS_A;
                        end
                    end
                end
                SEQ_REGB:
                begin
                    status_b = b;
                    s = snap_cur[0];
                    m = snap_cur[1];
                    h = snap_cur[2];
                    d = snap_cur[3];
                    mo = snap_cur[4];
                    yr = snap_cur[5];
                    ce = snap_cur[6];
                    if (!status_b[MODE_BIN])
                    begin
                        s = bcd_value(s);
                        m = bcd_value(m);
                        hv = h[3:0] + h[6:4] * 10;
                        h = {h[PM_BIT], hv[6:0]};
                        d = bcd_value(d);
                        mo = bcd_value(mo);
                        yr = bcd_value(yr);
                        if (cfg_century != 7'd0)
                            ce = bcd_value(ce);
                    end
                    if (!status_b[MODE_24H] && h[PM_BIT])
                    begin
                        hv = (h[6:0] + 12) % 24;
                        h = hv[7:0];
                    end
                    if (cfg_century != 7'd0)
                        year = yr + ce * 100;
                    else
                    begin
                        year = yr + (cfg_base_year / 100) * 100;
                        if (year < cfg_base_year)
                            year += 100;
                    end
                    r = {1'b1, 7'd0, s, m, h, d, mo, year[15:0]};
                    seq_phase = SEQ_IDLE;
                end
                default: has = 1'b0;
            endcase
        end
    endtask

    // chooses the next item as the emulated clock would answer the pending request
    task automatic pick_item(input bit clean, output logic op, output logic [7:0] b);
        int r;
        int i;
        logic [6:0] idx;
        logic [7:0] hr;
        r = $urandom_range(0, 99);
        op = OP_DATA;
        b = 8'($urandom);
        if (seq_phase != SEQ_IDLE && !clean && r < 1)
            op = OP_START;
        else
        begin
            case (seq_phase)
                SEQ_IDLE:
                begin
                    if (clean || r < 90)
                    begin
                        op = OP_START;
                        if ($urandom_range(0, 9) < 7)
                        begin
                            cmos_mem[field_idx[0]] = to_bcd($urandom_range(0, 59));
                            cmos_mem[field_idx[1]] = to_bcd($urandom_range(0, 59));
                            if ($urandom_range(0, 1))
                            begin
                                hr = to_bcd($urandom_range(0, 23));
                            end
                            else
                            begin
                                hr = to_bcd($urandom_range(1, 12));
                                hr[PM_BIT] = 1'($urandom_range(0, 1));
                            end
                            cmos_mem[field_idx[2]] = hr;
                            cmos_mem[field_idx[3]] = to_bcd($urandom_range(1, 31));
                            cmos_mem[field_idx[4]] = to_bcd($urandom_range(1, 12));
                            cmos_mem[field_idx[5]] = to_bcd($urandom_range(0, 99));
                            if (cfg_century != 7'd0)
                                cmos_mem[cfg_century] = to_bcd($urandom_range(19, 21));
                        end
                        else
                        begin
                            for (i = 0; i < 6; i++)
                                cmos_mem[field_idx[i]] = 8'($urandom);
                            cmos_mem[cfg_century] = 8'($urandom);
                        end
                    end
                end
                SEQ_POLL:
                begin
                    if (clean || r < 95)
                        b[UIP_BIT] = (r < 30);
                end
                SEQ_READ:
                begin
                    idx = (seq_pos < 3'd6) ? field_idx[seq_pos] : cfg_century;
                    if (clean || r < 96)
                    begin
                        // clock tick between reads
                        if (!clean && r >= 92)
                            cmos_mem[field_idx[$urandom_range(0, 5)]] = 8'($urandom);
                        b = cmos_mem[idx];
                    end
                end
                default: ;
            endcase
        end
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input dir_row_t row, output bit counted);
        logic has;
        rtc_res_t r;
        seq_phase_e was;
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.opcode <= row.op;
        req_ch.read_byte <= row.data;
        do @(posedge clk); while (!req_ch.ready);
        was = seq_phase;
        rtc_predict(row.op, row.data, has, r);
        if (row.op == OP_START && was != SEQ_IDLE)
            aborts++;
        if (row.op == OP_DATA && was == SEQ_IDLE)
            ignored++;
        if (row.op == OP_DATA && was == SEQ_POLL && row.data[UIP_BIT])
            uip_polls++;
        case (row.kind)
            ROW_NONE: has = 1'b0;
            ROW_REQ:
            begin
                has = 1'b1;
                r = '0;
                r.reg_index = row.idx;
            end
            ROW_TIME:
            begin
                has = 1'b1;
                r = {1'b1, 7'd0, row.sec, row.mnt, row.hr, row.dy, row.mon, row.yr};
            end
            default: ;
        endcase
        if (has && r.done_res)
            reads_done++;
        if (has)
            awaited_results.push_back(r);
        counted = has;
        @(negedge clk);
    endtask

    // called at a falling edge with valid already dropped
    task automatic wait_drain();
        do @(negedge clk); while (awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic sel, input logic [31:0] value);
        logic [31:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== value)
            report_mismatch(sel == REG_CENTURY ? "century_index readback"
                                               : "base_year readback", got, value);
        if (sel == REG_CENTURY)
            cfg_century = value[6:0];
        else
            cfg_base_year = value[13:0];
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still awaited",
                     cycles, awaited_results.size());
            $display("cmos_rtc_snapshot_reader verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rtc_res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result with nothing awaited", {25'd0, res_ch.reg_index},
                                32'd0);
            else
            begin
                want = awaited_results.pop_front();
                results_seen++;
                check_field("done_res", 16'(res_ch.done_res), 16'(want.done_res));
                check_field("reg_index", 16'(res_ch.reg_index), 16'(want.reg_index));
                check_field("sec_out", 16'(res_ch.sec_out), 16'(want.sec_out));
                check_field("min_out", 16'(res_ch.min_out), 16'(want.min_out));
                check_field("hour_out", 16'(res_ch.hour_out), 16'(want.hour_out));
                check_field("day_out", 16'(res_ch.day_out), 16'(want.day_out));
                check_field("month_out", 16'(res_ch.month_out), 16'(want.month_out));
                check_field("full_year", res_ch.full_year, want.full_year);
            end
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end
            else if (sink_gaps && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        dir_row_t row;
        bit counted;
        int n;
        int ph;
        logic [6:0]  cent_plan [NUM_SETTINGS];
        logic [13:0] year_plan [NUM_SETTINGS];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        req_ch.valid = 1'b0;
        req_ch.opcode = OP_START;
        req_ch.read_byte = 8'd0;
        cfg_century = 7'd0;
        cfg_base_year = 14'd2024;
        seq_phase = SEQ_IDLE;
        seq_pos = 3'd0;
        snap_valid = 1'b0;
        status_b = 8'd0;
        foreach (snap_cur[i])
        begin
            snap_cur[i] = 8'd0;
            snap_last[i] = 8'd0;
        end
        foreach (cmos_mem[i])
            cmos_mem[i] = 8'd0;
        hold_req = 1'b0;
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
        cent_plan = '{7'h32, 7'h7F, 7'h00, 7'h01, 7'h00, 7'h00};
        year_plan = '{14'd2024, 14'd0, 14'd9999, 14'd9999, 14'd0, 14'd0};
        cent_plan[4] = 7'($urandom_range(0, 127));
        year_plan[4] = 14'($urandom_range(0, 9999));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i], counted);

        for (ph = 0; ph < NUM_SETTINGS; ph++)
        begin
            // finish any read in progress before touching the registers
            while (seq_phase != SEQ_IDLE)
            begin
                row = '0;
                row.kind = ROW_MODEL;
                pick_item(1'b1, row.op, row.data);
                send_item(row, counted);
            end
            req_ch.valid <= 1'b0;
            wait_drain();
            cfg_write(REG_CENTURY, {25'd0, cent_plan[ph]});
            cfg_write(REG_BASE_YEAR, {18'd0, year_plan[ph]});
            if (ph == NUM_SETTINGS - 1)
            begin
                src_gaps = 1'b0;
                sink_gaps = 1'b0;
            end
            n = 0;
            while (n < RAND_ITEMS)
            begin
                row = '0;
                row.kind = ROW_MODEL;
                pick_item(1'b0, row.op, row.data);
                send_item(row, counted);
                if (counted)
                    n++;
                if (ph == 1 && n == 40 && counted)
                    hold_req = 1'b1;
                if (ph == 2 && n == 100 && counted)
                begin
                    req_ch.valid <= 1'b0;
                    do @(negedge clk); while (awaited_results.size() != 0);
                end
            end
        end
        req_ch.valid <= 1'b0;
        wait_drain();

        $display("Checked %0d results: %0d completed time reads, %0d polls with update set,",
                 results_seen, reads_done, uip_polls);
        $display("%0d snapshot retries, %0d aborted reads, %0d idle data items, %0d settings",
                 retries, aborts, ignored, NUM_SETTINGS + 1);
        if (mismatches == 0)
            $display("cmos_rtc_snapshot_reader verification clean");
        else
            $display("cmos_rtc_snapshot_reader verification failed");
        $finish;
    end

endmodule
